[hdl/tri2d_pkg.sv]
// Shared widths, types and register indexes of the 2D trilateration solver.
package tri2d_pkg;

    // Coordinate width; every internal width follows from it
    localparam int CW   = 32;
    localparam int RW   = CW - 1;          // range field
    localparam int DW   = CW + 1;          // anchor difference
    localparam int PW   = 2 * DW;          // product of two differences
    localparam int CRW  = PW + 1;          // cross product
    localparam int AW   = PW + 2;          // right-hand sides a and b
    localparam int SPL  = CW + 2;          // split point of a and b for partial products
    localparam int HPW  = AW - SPL + DW;   // high partial product
    localparam int LPW  = SPL + 1 + DW;    // low partial product
    localparam int NW   = AW + DW;         // numerators
    localparam int DENW = CRW + 1;         // denominator (twice the cross product)
    localparam int MW   = NW + 3;          // rounding dividend, signed
    localparam int QW   = CW + 2;          // quotient magnitude bits
    localparam int DDW  = DENW + 1;        // rounding divisor
    localparam int MAW  = DDW + QW;        // dividend magnitude
    localparam int SUMW = CW + 4;          // anchor plus quotient
    localparam int NFR  = 9;               // front pipeline stages
    localparam int DIVN = QW;              // divider stages, one quotient bit each
    localparam int CFGAW = 3;              // configuration index width
    localparam int TDIW = 96;              // input tdata width
    localparam int TDOW = 2 * CW;          // output tdata width
    localparam int TUW  = 2;               // output tuser width

    typedef logic signed [CW-1:0]   t_crd;
    typedef logic        [RW-1:0]   t_rng;
    typedef logic signed [DW-1:0]   t_dif;
    typedef logic        [2*RW-1:0] t_sq;
    typedef logic signed [PW-1:0]   t_prd;
    typedef logic signed [CRW-1:0]  t_crs;
    typedef logic signed [AW-1:0]   t_ab;
    typedef logic signed [HPW-1:0]  t_php;
    typedef logic signed [LPW-1:0]  t_plp;
    typedef logic signed [NW-1:0]   t_num;
    typedef logic signed [DENW-1:0] t_den;
    typedef logic signed [MW-1:0]   t_m;
    typedef logic        [MAW-1:0]  t_mab;
    typedef logic        [DDW-1:0]  t_dd;
    typedef logic        [QW-1:0]   t_quo;
    typedef logic signed [SUMW-1:0] t_sum;

    // Configuration register indexes
    typedef enum logic [CFGAW-1:0] {
        REG_A1X = 3'd0,
        REG_A1Y = 3'd1,
        REG_A2X = 3'd2,
        REG_A2Y = 3'd3,
        REG_A3X = 3'd4,
        REG_A3Y = 3'd5
    } t_reg;

    // Per-item control carried beside the divider lanes
    typedef struct packed {
        logic geo;
        logic negx;
        logic negy;
        logic ovfx;
        logic ovfy;
        t_crd p1x;
        t_crd p1y;
    } t_side;

    // One saturated axis result
    typedef struct packed {
        t_crd val;
        logic sat;
    } t_axres;

endpackage

[hdl/tri2d_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module tri2d_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  tri2d_pkg::t_dd  i_rem,
    input  tri2d_pkg::t_quo i_low,
    input  tri2d_pkg::t_dd  i_dd,
    output tri2d_pkg::t_quo o_quo
);

    tri2d_pkg::t_dd  r_rem [tri2d_pkg::DIVN];
    tri2d_pkg::t_dd  r_dd  [tri2d_pkg::DIVN];
    tri2d_pkg::t_quo r_low [tri2d_pkg::DIVN];
    tri2d_pkg::t_quo r_quo [tri2d_pkg::DIVN];
    tri2d_pkg::t_dd  n_rem [tri2d_pkg::DIVN];
    tri2d_pkg::t_quo n_low [tri2d_pkg::DIVN];
    tri2d_pkg::t_quo n_quo [tri2d_pkg::DIVN];
    tri2d_pkg::t_dd  s_rem [tri2d_pkg::DIVN];
    tri2d_pkg::t_dd  s_dd  [tri2d_pkg::DIVN];
    tri2d_pkg::t_quo s_low [tri2d_pkg::DIVN];
    tri2d_pkg::t_quo s_quo [tri2d_pkg::DIVN];
    logic [tri2d_pkg::DDW:0] w_try [tri2d_pkg::DIVN];
    logic [tri2d_pkg::DDW:0] w_dif [tri2d_pkg::DIVN];

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        for (int k = 0; k < tri2d_pkg::DIVN; k++) begin
            if (k == 0) begin
                s_rem[k] = i_rem;
                s_low[k] = i_low;
                s_quo[k] = '0;
                s_dd[k]  = i_dd;
            end else begin
                s_rem[k] = r_rem[k-1];
                s_low[k] = r_low[k-1];
                s_quo[k] = r_quo[k-1];
                s_dd[k]  = r_dd[k-1];
            end
            w_try[k] = {s_rem[k], s_low[k][tri2d_pkg::QW-1]};
            w_dif[k] = w_try[k] - {1'b0, s_dd[k]};
            n_rem[k] = w_dif[k][tri2d_pkg::DDW] ? w_try[k][tri2d_pkg::DDW-1:0]
                                                : w_dif[k][tri2d_pkg::DDW-1:0];
            n_quo[k] = {s_quo[k][tri2d_pkg::QW-2:0], ~w_dif[k][tri2d_pkg::DDW]};
            n_low[k] = {s_low[k][tri2d_pkg::QW-2:0], 1'b0};
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < tri2d_pkg::DIVN; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_dd[k]  <= s_dd[k];
            end
        end
    end

    assign o_quo = r_quo[tri2d_pkg::DIVN-1];

endmodule

[hdl/trilateration_2d_solver_unit.sv]
// 2D trilateration solver: three ranges in, one position out, pipelined.
//
// Each input transaction carries three ranges (unsigned Q15.16) to the anchors held in the
// six configuration registers; each output transaction carries the position as signed
// Q16.16, rounded to nearest (ties up) and saturated, with flags for collinear anchors and
// for clipping. One transaction is taken every cycle unless stalled. The pipeline has
// nine stages of differences, squares, partial products and sums, 34 divider stages that
// each produce one quotient bit per axis, and the output register. The output register
// decouples the sides, so input is still taken while a result waits as long as the last
// pipeline stage is empty. Write the anchors only while no transaction is in flight.
module trilateration_2d_solver_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tri2d_pkg::CFGAW-1:0]   i_cfg_addr,
    input  logic [tri2d_pkg::CW-1:0]      i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // range_one [30:0], range_two [61:31], range_three [92:62], zero [95:93]
    input  logic [tri2d_pkg::TDIW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pos_x [31:0], pos_y [63:32]
    output logic [tri2d_pkg::TDOW-1:0]    m_axis_tdata,
    // geometry_error [0], saturated [1]
    output logic [tri2d_pkg::TUW-1:0]     m_axis_tuser
);

    // Anchor registers
    tri2d_pkg::t_crd r_a1x, r_a1y, r_a2x, r_a2y, r_a3x, r_a3y;

    // Pipeline control
    logic [tri2d_pkg::NFR-1:0]  r_v;
    logic [tri2d_pkg::DIVN-1:0] r_sdv;
    logic                       r_ovld;
    logic                       w_adv;

    // Stage 1
    tri2d_pkg::t_rng r1_r1, r1_r2, r1_r3;
    tri2d_pkg::t_crd r1_p1x, r1_p1y;
    tri2d_pkg::t_dif r1_ux, r1_uy, r1_vx, r1_vy;
    // Stage 2
    tri2d_pkg::t_sq  r2_sq1, r2_sq2, r2_sq3;
    tri2d_pkg::t_prd r2_uxx, r2_uyy, r2_vxx, r2_vyy, r2_uxvy, r2_uyvx;
    tri2d_pkg::t_dif r2_ux, r2_uy, r2_vx, r2_vy;
    tri2d_pkg::t_crd r2_p1x, r2_p1y;
    // Stage 3
    tri2d_pkg::t_ab  r3_a, r3_b;
    tri2d_pkg::t_crs r3_cross;
    tri2d_pkg::t_dif r3_ux, r3_uy, r3_vx, r3_vy;
    tri2d_pkg::t_crd r3_p1x, r3_p1y;
    // Stage 4
    tri2d_pkg::t_php r4_hvy, r4_huy, r4_hux, r4_hvx;
    tri2d_pkg::t_plp r4_lvy, r4_luy, r4_lux, r4_lvx;
    tri2d_pkg::t_den r4_den;
    logic            r4_geo;
    tri2d_pkg::t_crd r4_p1x, r4_p1y;
    // Stage 5
    tri2d_pkg::t_num r5_avy, r5_buy, r5_bux, r5_avx;
    tri2d_pkg::t_den r5_den;
    logic            r5_geo;
    tri2d_pkg::t_crd r5_p1x, r5_p1y;
    // Stage 6
    tri2d_pkg::t_num r6_nx, r6_ny;
    tri2d_pkg::t_den r6_den;
    logic            r6_geo;
    tri2d_pkg::t_crd r6_p1x, r6_p1y;
    // Stage 7
    tri2d_pkg::t_m   r7_mx, r7_my;
    tri2d_pkg::t_dd  r7_dd;
    logic            r7_dneg, r7_geo;
    tri2d_pkg::t_crd r7_p1x, r7_p1y;
    // Stage 8
    tri2d_pkg::t_m   r8_ex, r8_ey;
    tri2d_pkg::t_dd  r8_dd;
    logic            r8_geo;
    tri2d_pkg::t_crd r8_p1x, r8_p1y;
    // Stage 9
    tri2d_pkg::t_mab r9_mabx, r9_maby;
    tri2d_pkg::t_dd  r9_dd;
    logic            r9_negx, r9_negy, r9_ovfx, r9_ovfy, r9_geo;
    tri2d_pkg::t_crd r9_p1x, r9_p1y;
    // Divider side band
    tri2d_pkg::t_side r_sd [tri2d_pkg::DIVN];
    tri2d_pkg::t_side w_sd9;
    // Output register
    tri2d_pkg::t_crd r_px, r_py;
    logic            r_geo, r_sat;

    // Combinational values of the stages
    tri2d_pkg::t_dif  n_ux, n_uy, n_vx, n_vy;
    tri2d_pkg::t_sq   n_sq1, n_sq2, n_sq3;
    tri2d_pkg::t_prd  n_uxx, n_uyy, n_vxx, n_vyy, n_uxvy, n_uyvx;
    tri2d_pkg::t_ab   n_a, n_b;
    tri2d_pkg::t_crs  n_cross;
    tri2d_pkg::t_php  n_hvy, n_huy, n_hux, n_hvx;
    tri2d_pkg::t_plp  n_lvy, n_luy, n_lux, n_lvx;
    tri2d_pkg::t_num  n_avy, n_buy, n_bux, n_avx, n_nx, n_ny;
    tri2d_pkg::t_m    n_mx, n_my, n_ex, n_ey;
    logic [tri2d_pkg::DENW-1:0] w_dabs;
    tri2d_pkg::t_dd   n_dd;
    tri2d_pkg::t_mab  n_mabx, n_maby;
    tri2d_pkg::t_quo  w_qx, w_qy;
    tri2d_pkg::t_axres w_rx, w_ry;

    // Round-adjusted quotient plus anchor, then clip to the coordinate range
    function automatic tri2d_pkg::t_axres f_axis(tri2d_pkg::t_crd p1, tri2d_pkg::t_quo q,
                                                 logic neg, logic ovf);
        tri2d_pkg::t_sum    qz;
        tri2d_pkg::t_sum    sum;
        tri2d_pkg::t_axres  res;
        logic               fits;
        qz   = tri2d_pkg::t_sum'({{(tri2d_pkg::SUMW-tri2d_pkg::QW){1'b0}}, q});
        sum  = tri2d_pkg::t_sum'(p1) + (neg ? ~qz : qz);
        fits = (sum[tri2d_pkg::SUMW-1:tri2d_pkg::CW-1] == '0) ||
               (sum[tri2d_pkg::SUMW-1:tri2d_pkg::CW-1] == '1);
        if (ovf || !fits) begin
            res.sat = 1'b1;
            res.val = (ovf ? neg : sum[tri2d_pkg::SUMW-1])
                      ? {1'b1, {(tri2d_pkg::CW-1){1'b0}}}
                      : {1'b0, {(tri2d_pkg::CW-1){1'b1}}};
        end else begin
            res.sat = 1'b0;
            res.val = sum[tri2d_pkg::CW-1:0];
        end
        return res;
    endfunction

    // Advance when the last stage is empty or its result can move to the output
    assign w_adv         = !r_sdv[tri2d_pkg::DIVN-1] || !r_ovld || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Write anchor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1x <= '0;
            r_a1y <= '0;
            r_a2x <= '0;
            r_a2y <= '0;
            r_a3x <= '0;
            r_a3y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tri2d_pkg::REG_A1X: r_a1x <= i_cfg_wdata;
                tri2d_pkg::REG_A1Y: r_a1y <= i_cfg_wdata;
                tri2d_pkg::REG_A2X: r_a2x <= i_cfg_wdata;
                tri2d_pkg::REG_A2Y: r_a2y <= i_cfg_wdata;
                tri2d_pkg::REG_A3X: r_a3x <= i_cfg_wdata;
                tri2d_pkg::REG_A3Y: r_a3y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage arithmetic
    always_comb begin
        n_ux = tri2d_pkg::t_dif'(r_a2x) - tri2d_pkg::t_dif'(r_a1x);
        n_uy = tri2d_pkg::t_dif'(r_a2y) - tri2d_pkg::t_dif'(r_a1y);
        n_vx = tri2d_pkg::t_dif'(r_a3x) - tri2d_pkg::t_dif'(r_a1x);
        n_vy = tri2d_pkg::t_dif'(r_a3y) - tri2d_pkg::t_dif'(r_a1y);

        n_sq1  = r1_r1 * r1_r1;
        n_sq2  = r1_r2 * r1_r2;
        n_sq3  = r1_r3 * r1_r3;
        n_uxx  = r1_ux * r1_ux;
        n_uyy  = r1_uy * r1_uy;
        n_vxx  = r1_vx * r1_vx;
        n_vyy  = r1_vy * r1_vy;
        n_uxvy = r1_ux * r1_vy;
        n_uyvx = r1_uy * r1_vx;

        n_a = tri2d_pkg::t_ab'(r2_sq1) - tri2d_pkg::t_ab'(r2_sq2)
            + tri2d_pkg::t_ab'(r2_uxx) + tri2d_pkg::t_ab'(r2_uyy);
        n_b = tri2d_pkg::t_ab'(r2_sq1) - tri2d_pkg::t_ab'(r2_sq3)
            + tri2d_pkg::t_ab'(r2_vxx) + tri2d_pkg::t_ab'(r2_vyy);
        n_cross = tri2d_pkg::t_crs'(r2_uxvy) - tri2d_pkg::t_crs'(r2_uyvx);

        // Split a and b into a signed high part and an unsigned low part
        n_hvy = $signed(r3_a[tri2d_pkg::AW-1:tri2d_pkg::SPL]) * r3_vy;
        n_hvx = $signed(r3_a[tri2d_pkg::AW-1:tri2d_pkg::SPL]) * r3_vx;
        n_huy = $signed(r3_b[tri2d_pkg::AW-1:tri2d_pkg::SPL]) * r3_uy;
        n_hux = $signed(r3_b[tri2d_pkg::AW-1:tri2d_pkg::SPL]) * r3_ux;
        n_lvy = $signed({1'b0, r3_a[tri2d_pkg::SPL-1:0]}) * r3_vy;
        n_lvx = $signed({1'b0, r3_a[tri2d_pkg::SPL-1:0]}) * r3_vx;
        n_luy = $signed({1'b0, r3_b[tri2d_pkg::SPL-1:0]}) * r3_uy;
        n_lux = $signed({1'b0, r3_b[tri2d_pkg::SPL-1:0]}) * r3_ux;

        n_avy = (tri2d_pkg::t_num'(r4_hvy) <<< tri2d_pkg::SPL) + tri2d_pkg::t_num'(r4_lvy);
        n_avx = (tri2d_pkg::t_num'(r4_hvx) <<< tri2d_pkg::SPL) + tri2d_pkg::t_num'(r4_lvx);
        n_buy = (tri2d_pkg::t_num'(r4_huy) <<< tri2d_pkg::SPL) + tri2d_pkg::t_num'(r4_luy);
        n_bux = (tri2d_pkg::t_num'(r4_hux) <<< tri2d_pkg::SPL) + tri2d_pkg::t_num'(r4_lux);

        n_nx = r5_avy - r5_buy;
        n_ny = r5_bux - r5_avx;

        // Rounding dividend 2n+den over divisor 2|den|
        n_mx   = (tri2d_pkg::t_m'(r6_nx) <<< 1) + tri2d_pkg::t_m'(r6_den);
        n_my   = (tri2d_pkg::t_m'(r6_ny) <<< 1) + tri2d_pkg::t_m'(r6_den);
        w_dabs = r6_den[tri2d_pkg::DENW-1] ? -r6_den : r6_den;
        n_dd   = {w_dabs, 1'b0};

        // Flip both signs when the denominator is negative
        n_ex = r7_dneg ? -r7_mx : r7_mx;
        n_ey = r7_dneg ? -r7_my : r7_my;

        // Floor of a negative dividend is the complement of the quotient of its complement
        n_mabx = r8_ex[tri2d_pkg::MW-1] ? ~r8_ex[tri2d_pkg::MAW-1:0] : r8_ex[tri2d_pkg::MAW-1:0];
        n_maby = r8_ey[tri2d_pkg::MW-1] ? ~r8_ey[tri2d_pkg::MAW-1:0] : r8_ey[tri2d_pkg::MAW-1:0];

        w_sd9.geo  = r9_geo;
        w_sd9.negx = r9_negx;
        w_sd9.negy = r9_negy;
        w_sd9.ovfx = r9_ovfx;
        w_sd9.ovfy = r9_ovfy;
        w_sd9.p1x  = r9_p1x;
        w_sd9.p1y  = r9_p1y;

        w_rx = f_axis(r_sd[tri2d_pkg::DIVN-1].p1x, w_qx,
                      r_sd[tri2d_pkg::DIVN-1].negx, r_sd[tri2d_pkg::DIVN-1].ovfx);
        w_ry = f_axis(r_sd[tri2d_pkg::DIVN-1].p1y, w_qy,
                      r_sd[tri2d_pkg::DIVN-1].negy, r_sd[tri2d_pkg::DIVN-1].ovfy);
    end

    // Move valid bits and the output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_sdv  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_v   <= {r_v[tri2d_pkg::NFR-2:0], s_axis_tvalid};
                r_sdv <= {r_sdv[tri2d_pkg::DIVN-2:0], r_v[tri2d_pkg::NFR-1]};
            end
            if (w_adv && r_sdv[tri2d_pkg::DIVN-1]) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Advance stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_r1  <= s_axis_tdata[tri2d_pkg::RW-1:0];
            r1_r2  <= s_axis_tdata[2*tri2d_pkg::RW-1:tri2d_pkg::RW];
            r1_r3  <= s_axis_tdata[3*tri2d_pkg::RW-1:2*tri2d_pkg::RW];
            r1_p1x <= r_a1x;
            r1_p1y <= r_a1y;
            r1_ux  <= n_ux;
            r1_uy  <= n_uy;
            r1_vx  <= n_vx;
            r1_vy  <= n_vy;

            r2_sq1  <= n_sq1;
            r2_sq2  <= n_sq2;
            r2_sq3  <= n_sq3;
            r2_uxx  <= n_uxx;
            r2_uyy  <= n_uyy;
            r2_vxx  <= n_vxx;
            r2_vyy  <= n_vyy;
            r2_uxvy <= n_uxvy;
            r2_uyvx <= n_uyvx;
            r2_ux   <= r1_ux;
            r2_uy   <= r1_uy;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_p1x  <= r1_p1x;
            r2_p1y  <= r1_p1y;

            r3_a     <= n_a;
            r3_b     <= n_b;
            r3_cross <= n_cross;
            r3_ux    <= r2_ux;
            r3_uy    <= r2_uy;
            r3_vx    <= r2_vx;
            r3_vy    <= r2_vy;
            r3_p1x   <= r2_p1x;
            r3_p1y   <= r2_p1y;

            r4_hvy <= n_hvy;
            r4_huy <= n_huy;
            r4_hux <= n_hux;
            r4_hvx <= n_hvx;
            r4_lvy <= n_lvy;
            r4_luy <= n_luy;
            r4_lux <= n_lux;
            r4_lvx <= n_lvx;
            r4_den <= {r3_cross, 1'b0};
            r4_geo <= (r3_cross == '0);
            r4_p1x <= r3_p1x;
            r4_p1y <= r3_p1y;

            r5_avy <= n_avy;
            r5_buy <= n_buy;
            r5_bux <= n_bux;
            r5_avx <= n_avx;
            r5_den <= r4_den;
            r5_geo <= r4_geo;
            r5_p1x <= r4_p1x;
            r5_p1y <= r4_p1y;

            r6_nx  <= n_nx;
            r6_ny  <= n_ny;
            r6_den <= r5_den;
            r6_geo <= r5_geo;
            r6_p1x <= r5_p1x;
            r6_p1y <= r5_p1y;

            r7_mx   <= n_mx;
            r7_my   <= n_my;
            r7_dd   <= n_dd;
            r7_dneg <= r6_den[tri2d_pkg::DENW-1];
            r7_geo  <= r6_geo;
            r7_p1x  <= r6_p1x;
            r7_p1y  <= r6_p1y;

            r8_ex  <= n_ex;
            r8_ey  <= n_ey;
            r8_dd  <= r7_dd;
            r8_geo <= r7_geo;
            r8_p1x <= r7_p1x;
            r8_p1y <= r7_p1y;

            r9_mabx <= n_mabx;
            r9_maby <= n_maby;
            r9_negx <= r8_ex[tri2d_pkg::MW-1];
            r9_negy <= r8_ey[tri2d_pkg::MW-1];
            r9_ovfx <= (n_mabx[tri2d_pkg::MAW-1:tri2d_pkg::QW] >= r8_dd);
            r9_ovfy <= (n_maby[tri2d_pkg::MAW-1:tri2d_pkg::QW] >= r8_dd);
            r9_dd   <= r8_dd;
            r9_geo  <= r8_geo;
            r9_p1x  <= r8_p1x;
            r9_p1y  <= r8_p1y;

            r_sd[0] <= w_sd9;
            for (int k = 1; k < tri2d_pkg::DIVN; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Load the output register from the last stage
    always_ff @(posedge i_clk) begin
        if (w_adv && r_sdv[tri2d_pkg::DIVN-1]) begin
            if (r_sd[tri2d_pkg::DIVN-1].geo) begin
                r_px  <= '0;
                r_py  <= '0;
                r_geo <= 1'b1;
                r_sat <= 1'b0;
            end else begin
                r_px  <= w_rx.val;
                r_py  <= w_ry.val;
                r_geo <= 1'b0;
                r_sat <= w_rx.sat | w_ry.sat;
            end
        end
    end

    tri2d_div u_divx (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem (r9_mabx[tri2d_pkg::MAW-1:tri2d_pkg::QW]),
        .i_low (r9_mabx[tri2d_pkg::QW-1:0]),
        .i_dd  (r9_dd),
        .o_quo (w_qx)
    );

    tri2d_div u_divy (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem (r9_maby[tri2d_pkg::MAW-1:tri2d_pkg::QW]),
        .i_low (r9_maby[tri2d_pkg::QW-1:0]),
        .i_dd  (r9_dd),
        .o_quo (w_qy)
    );

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_py, r_px};
    assign m_axis_tuser  = {r_sat, r_geo};

endmodule

[hdl/tri2d_chk.sv]
// Port-level checks of the trilateration solver, bound to the top level.
module tri2d_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [tri2d_pkg::TDOW-1:0]  m_axis_tdata,
    input logic [tri2d_pkg::TUW-1:0]   m_axis_tuser
);

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A waiting result holds still
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    // Input is never blocked while the output can move
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input blocked with free output");

    // Collinear anchors give a zero position and no clipping
    a_geo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("geometry error with nonzero result");

endmodule

bind trilateration_2d_solver_unit tri2d_chk u_tri2d_chk (.*);
